// ===== rtl/nlpib_pkg.sv =====
// Shared types, codes and helper functions of the nested-level parent-index builder.
// Depends on nothing; nlpib_cfg and the top level import it.
package nlpib_pkg;

    // Level kinds as coded in the kinds register, two bits per level.
    typedef enum logic [1:0] {
        KIND_REQUIRED = 2'd0,
        KIND_OPTIONAL = 2'd1,
        KIND_REPEATED = 2'd2
    } t_kind;

    // Input command codes.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Register select, taken from byte address bit 2.
    localparam logic REG_LEVEL_COUNT = 1'b0;
    localparam logic REG_LEVEL_KINDS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic       func;
        logic [2:0] def_lvl;
        logic [2:0] rep_lvl;
    } t_in;

    typedef struct packed {
        logic [2:0]  level;
        logic [31:0] parent_index;
        logic        last;
    } t_out;

    // Configuration as seen by the level walker.
    typedef struct packed {
        logic [3:0]  last_lvl;
        logic [15:0] kinds;
        logic [3:0]  max_def;
        logic [3:0]  max_rep;
    } t_cfg;

    // Kind of one level. Level 0 is always repeated, code three reads as repeated
    // and levels past the kinds register read as required.
    function automatic t_kind kind_of(input logic [15:0] kinds, input logic [3:0] lvl);
        t_kind k;
        if (lvl == 4'd0) begin
            k = KIND_REPEATED;
        end else if (lvl[3]) begin
            k = KIND_REQUIRED;
        end else begin
            unique case (kinds[{lvl[2:0], 1'b0} +: 2])
                KIND_REQUIRED: k = KIND_REQUIRED;
                KIND_OPTIONAL: k = KIND_OPTIONAL;
                default:       k = KIND_REPEATED;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== rtl/nlpib_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module nlpib_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/nlpib_cfg.sv =====
// Configuration registers of the parent-index builder behind an APB-style port,
// plus the derived level limits. Depends on nlpib_pkg.
module nlpib_cfg
    import nlpib_pkg::*;
#(
    parameter int MAX_LEVELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [3:0]  r_level_count;
    logic [15:0] r_level_kinds;
    logic        wr_en;
    logic [4:0]  used;
    logic [4:0]  non_req_total;
    logic [4:0]  rep_total;
    t_kind       k;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= 4'd1;
            r_level_kinds <= 16'd2;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LEVEL_COUNT: r_level_count <= pwdata[3:0];
                REG_LEVEL_KINDS: r_level_kinds <= pwdata[15:0];
                default:         r_level_count <= r_level_count;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LEVEL_COUNT: prdata = {28'd0, r_level_count};
            REG_LEVEL_KINDS: prdata = {16'd0, r_level_kinds};
            default:         prdata = 32'd0;
        endcase
    end

    // Number of levels in use: zero means one, and the count saturates at the
    // number of levels the block was built for.
    always_comb begin
        if (r_level_count == 4'd0) begin
            used = 5'd1;
        end else if ({1'b0, r_level_count} > 5'(MAX_LEVELS)) begin
            used = 5'(MAX_LEVELS);
        end else begin
            used = {1'b0, r_level_count};
        end
    end

    // Level 0 is repeated, so both totals are at least one.
    always_comb begin
        non_req_total = 5'd0;
        rep_total     = 5'd0;
        k             = KIND_REQUIRED;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (5'(i) < used) begin
                k = kind_of(r_level_kinds, 4'(i));
                if (k != KIND_REQUIRED) begin
                    non_req_total = non_req_total + 5'd1;
                end
                if (k == KIND_REPEATED) begin
                    rep_total = rep_total + 5'd1;
                end
            end
        end
    end

    assign o_cfg.last_lvl = 4'(used - 5'd1);
    assign o_cfg.kinds    = r_level_kinds;
    assign o_cfg.max_def  = 4'(non_req_total - 5'd1);
    assign o_cfg.max_rep  = 4'(rep_total - 5'd1);

endmodule

// ===== rtl/nested_level_parent_index_builder.sv =====
// Top level of the nested-level parent-index builder: level walker, state RAM
// and output register. Depends on nlpib_pkg, nlpib_cfg and nlpib_ram.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   i_in_data  (t_in)
//   output    out        o_out_valid / i_out_stall o_out_data (t_out)
//   config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// A clear transaction clears the per-level valid bits. An add transaction is accepted
// in the idle state, then the walker steps level by level (at most the configured count
// of 1 to MAX_LEVELS; a null value ends the walk early) through the per-level state RAM,
// reading each level and writing it back when it yields a result, and the flush state
// releases the final result when the value produced any.
// Output stalls lengthen the walk only when a new result finds the held one waiting
// on a full output register; the final result likewise waits for room at the output.
// Reset clears the state machine, the output register and the per-level valid bits;
// a level whose valid bit is low reads as an empty list, so no clearing pass runs.
module nested_level_parent_index_builder
    import nlpib_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int INDEX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int ENTRY_W = 2 * INDEX_WIDTH;
    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = '1;

    t_cfg cfg;

    nlpib_cfg #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Walker state.
    t_state                  r_state, n_state;
    logic [LVL_W-1:0]        r_lvl, n_lvl;
    logic [LVL_W-1:0]        r_last_lvl, n_last_lvl;
    logic [4:0]              r_non_req, n_non_req;
    logic [2:0]              r_rl, n_rl;
    logic [2:0]              r_dl, n_dl;
    logic [INDEX_WIDTH-1:0]  r_prev_cnt, n_prev_cnt;
    logic [MAX_LEVELS-1:0]   r_vld, n_vld;
    t_out                    r_pend, n_pend;
    logic                    r_pend_vld, n_pend_vld;
    t_out                    r_out, n_out;
    logic                    r_out_vld, n_out_vld;

    // State RAM: each entry holds {entry count, last entry} of one level.
    logic                    ram_we;
    logic [LVL_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;

    nlpib_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_LEVELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lvl),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // One walk step on the level in r_lvl, whose RAM data arrives this cycle.
    t_kind                   kind;
    logic [4:0]              nr;
    logic                    brk;
    logic                    skip;
    logic [INDEX_WIDTH-1:0]  cur_cnt;
    logic [INDEX_WIDTH-1:0]  cur_last;
    logic [INDEX_WIDTH-1:0]  idx;
    logic [INDEX_WIDTH-1:0]  new_cnt;
    logic                    append;
    logic                    emit;
    logic                    at_last;
    logic                    out_free;
    logic                    hold;
    logic                    push;
    logic                    push_last;

    always_comb begin
        kind     = kind_of(cfg.kinds, 4'(r_lvl));
        nr       = r_non_req + ((kind != KIND_REQUIRED) ? 5'd1 : 5'd0);
        // A null value stops the walk once the non-required levels pass its definition level.
        brk      = (cfg.max_def != 4'd0) && ({1'b0, r_dl} < cfg.max_def)
                   && (nr > ({2'b00, r_dl} + 5'd1));
        // Levels are skipped until the repetition level is used up.
        skip     = !brk && (cfg.max_rep != 4'd0) && (r_rl != 3'd0);
        cur_cnt  = r_vld[r_lvl] ? ram_rdata[ENTRY_W-1:INDEX_WIDTH] : '0;
        cur_last = r_vld[r_lvl] ? ram_rdata[INDEX_WIDTH-1:0] : '0;
        if ((r_lvl == '0) || (r_prev_cnt == '0)) begin
            idx = '0;
        end else begin
            idx = r_prev_cnt - INDEX_WIDTH'(1);
        end
        // An optional level does not repeat an index that is already its last entry.
        append   = !((kind == KIND_OPTIONAL) && (cur_cnt != '0) && (cur_last == idx));
        emit     = !brk && !skip && append;
        new_cnt  = (cur_cnt == INDEX_MAX) ? cur_cnt : cur_cnt + INDEX_WIDTH'(1);
        at_last  = (r_lvl == r_last_lvl);
        out_free = !r_out_vld || !i_out_stall;
        // A new result pushes the held one out, which needs room at the output.
        hold     = emit && r_pend_vld && !out_free;
    end

    always_comb begin
        n_state    = r_state;
        n_lvl      = r_lvl;
        n_last_lvl = r_last_lvl;
        n_non_req  = r_non_req;
        n_rl       = r_rl;
        n_dl       = r_dl;
        n_prev_cnt = r_prev_cnt;
        n_vld      = r_vld;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        ram_we     = 1'b0;
        ram_raddr  = '0;
        ram_wdata  = {new_cnt, idx};
        push       = 1'b0;
        push_last  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // The read of level 0 goes out now so that its data meets the first step.
                ram_raddr = '0;
                if (i_in_valid) begin
                    if (i_in_data.func == FUNC_CLEAR) begin
                        n_vld = '0;
                    end else begin
                        n_lvl      = '0;
                        n_last_lvl = LVL_W'(cfg.last_lvl);
                        n_non_req  = 5'd0;
                        n_rl       = i_in_data.rep_lvl;
                        n_dl       = i_in_data.def_lvl;
                        n_state    = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (hold) begin
                    ram_raddr = r_lvl;
                end else begin
                    ram_raddr  = at_last ? r_lvl : r_lvl + LVL_W'(1);
                    n_lvl      = at_last ? r_lvl : r_lvl + LVL_W'(1);
                    n_non_req  = nr;
                    n_prev_cnt = emit ? new_cnt : cur_cnt;
                    if (skip && (kind == KIND_REPEATED)) begin
                        n_rl = r_rl - 3'd1;
                    end
                    if (emit) begin
                        ram_we       = 1'b1;
                        n_vld[r_lvl] = 1'b1;
                        push         = r_pend_vld;
                        n_pend.level        = 3'(r_lvl);
                        n_pend.parent_index = 32'(idx);
                        n_pend.last         = 1'b0;
                        n_pend_vld          = 1'b1;
                    end
                    if (brk || at_last) begin
                        n_state = (emit || r_pend_vld) ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                // The held result is the final one of this value.
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        if (push) begin
            n_out.level        = r_pend.level;
            n_out.parent_index = r_pend.parent_index;
            n_out.last         = push_last;
            n_out_vld          = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_vld      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vld      <= n_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_last_lvl <= n_last_lvl;
        r_non_req  <= n_non_req;
        r_rl       <= n_rl;
        r_dl       <= n_dl;
        r_prev_cnt <= n_prev_cnt;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
